@@ rtl/core/compact_target_work_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the compact target work block
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef COMPACT_TARGET_WORK_ASSERT_SVH
`define COMPACT_TARGET_WORK_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that is suspended while reset is high.
`define CTW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs through reset.
`define CTW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTW_ASSERT(label, clk, rst, prop, msg)
`define CTW_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/core/ctw_pkg.sv @@
// ----------------------------------------------------------------------------
// ctw_pkg
// Widths and the per-cell record shared by the compact target work pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ctw_pkg;

   localparam int BITS_W     = 32;   // compact difficulty word
   localparam int WORK_W     = 256;  // target, divisor and quotient
   localparam int REM_W      = 255;  // partial remainder, always below the divisor
   localparam int CELL_COUNT = 256;  // one quotient bit per cell

   // Data handed from one divider cell to the next. The dividend is shifted
   // out of the top of nq while quotient bits are shifted in at the bottom.
   typedef struct packed {
      logic              valid;
      logic              invalid;
      logic [WORK_W-1:0] divisor;
      logic [REM_W-1:0]  rem;
      logic [WORK_W-1:0] nq;
   } cell_type;

endpackage

`default_nettype wire

@@ rtl/core/ctw_expand.sv @@
// ----------------------------------------------------------------------------
// ctw_expand
// Two-stage front end: decodes the compact word into a 256-bit target and
// prepares the divider operands (inverted target and target plus one).
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_expand (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic                        bits_valid,
   input  wire logic [ctw_pkg::BITS_W-1:0]  bits,
   output ctw_pkg::cell_type                cell_o
);

   logic [7:0]                  expo;
   logic [22:0]                 mant;
   logic                        sign;
   logic                        negative;
   logic                        overflow;
   logic                        zero;
   logic [1:0]                  small_shift;
   logic [4:0]                  big_shift;
   logic [22:0]                 small_val;
   logic [ctw_pkg::WORK_W-1:0]  mant_ext;
   logic [ctw_pkg::WORK_W-1:0]  small_ext;

   logic                        a_valid_ff, a_valid_in;
   logic                        a_invalid_ff, a_invalid_in;
   logic [ctw_pkg::WORK_W-1:0]  a_target_ff, a_target_in;
   ctw_pkg::cell_type           b_ff, b_in;

   always_comb begin
      expo     = bits[31:24];
      sign     = bits[23];
      mant     = bits[22:0];
      negative = (mant != '0) && sign;
      overflow = (mant != '0) &&
                 ((expo > 8'd34) ||
                  ((mant > 23'h0000ff) && (expo > 8'd33)) ||
                  ((mant > 23'h00ffff) && (expo > 8'd32)));

      // Exponents up to three drop whole bytes off the mantissa.
      small_shift = 2'(8'd3 - expo);
      small_val   = mant >> {small_shift, 3'b000};
      small_ext   = '0;
      small_ext[22:0] = small_val;

      // Larger exponents move the mantissa up by whole bytes.
      big_shift   = 5'(expo - 8'd3);
      mant_ext    = '0;
      mant_ext[22:0] = mant;

      zero = (mant == '0) || ((expo <= 8'd3) && (small_val == '0));

      a_valid_in   = bits_valid;
      a_invalid_in = negative || overflow || zero;
      a_target_in  = (expo <= 8'd3) ? small_ext : (mant_ext << {big_shift, 3'b000});

      b_in.valid   = a_valid_ff;
      b_in.invalid = a_invalid_ff;
      b_in.divisor = a_target_ff + {{(ctw_pkg::WORK_W-1){1'b0}}, 1'b1};
      b_in.rem     = '0;
      b_in.nq      = ~a_target_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (enable) begin
         a_valid_ff   <= a_valid_in;
         a_invalid_ff <= a_invalid_in;
         a_target_ff  <= a_target_in;
         b_ff         <= b_in;
      end
   end

   assign cell_o = b_ff;

endmodule

`default_nettype wire

@@ rtl/core/ctw_cell.sv @@
// ----------------------------------------------------------------------------
// ctw_cell
// One restoring-division cell: brings down one dividend bit, trial-subtracts
// the divisor and shifts the resulting quotient bit into the record.
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire ctw_pkg::cell_type cell_i,
   output ctw_pkg::cell_type      cell_o
);

   logic [ctw_pkg::WORK_W-1:0] rem_shift;
   logic [ctw_pkg::WORK_W:0]   diff;
   logic                       fits;
   ctw_pkg::cell_type          cell_ff, cell_in;

   always_comb begin
      rem_shift = {cell_i.rem, cell_i.nq[ctw_pkg::WORK_W-1]};
      diff      = {1'b0, rem_shift} - {1'b0, cell_i.divisor};
      fits      = ~diff[ctw_pkg::WORK_W];

      cell_in         = cell_i;
      cell_in.rem     = fits ? diff[ctw_pkg::REM_W-1:0] : rem_shift[ctw_pkg::REM_W-1:0];
      cell_in.nq      = {cell_i.nq[ctw_pkg::WORK_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

`default_nettype wire

@@ rtl/core/compact_target_work.sv @@
// ----------------------------------------------------------------------------
// compact_target_work
// Proof-of-work value of a compact difficulty word, floor(2^256 / (T + 1)),
// computed by a fully pipelined chain of restoring-division cells.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (low bit first)              | tuser
//  ---------+-----------+------------------------------------+----------------
//  req_     | in        | compact_bits[31:0]                 | -
//  rsp_     | out       | work_word0 .. work_word3 (4 x 64)  | target_invalid
//
// A new compact word can be accepted and one result leaves in every cycle while
// the skid register is empty. The path holds two front-end stages, 256 division
// cells (one quotient bit each) and the output register that adds the final one.
// Reset is synchronous and active high; it clears all valid bits, the payload
// registers are left as they are.
// The whole pipeline advances together. A two-entry output buffer (output
// register plus skid register) absorbs one transfer when the consumer stalls,
// and req_tready is taken from the registered skid state, so there is no
// combinational path from rsp_tready to req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compact_target_work_assert.svh"

module compact_target_work (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [31:0]  req_tdata,    // [31:0] compact_bits

   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [255:0] rsp_tdata,    // [63:0] work_word0, [127:64] work_word1,
                                           // [191:128] work_word2, [255:192] work_word3
   output      logic         rsp_tuser     // [0] target_invalid
);

   typedef struct packed {
      logic                       invalid;
      logic [ctw_pkg::WORK_W-1:0] work;
   } result_type;

   // Pipeline advance enable, shared by every stage of the chain.
   logic                enable;

   // Record passed down the chain; entry 0 comes from the front end.
   ctw_pkg::cell_type   chain [0:ctw_pkg::CELL_COUNT];
   ctw_pkg::cell_type   last;

   result_type          new_result;
   logic                take;
   logic                pop;

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   result_type          out_data_ff, out_data_in;
   result_type          skid_data_ff, skid_data_in;

   // The chain only moves while the skid register is free, so one extra
   // result can always be caught when the output is stalled.
   assign enable     = ~skid_valid_ff;
   assign req_tready = enable;

   ctw_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .bits_valid (req_tvalid & req_tready),
      .bits       (req_tdata),
      .cell_o     (chain[0])
   );

   for (genvar g = 0; g < ctw_pkg::CELL_COUNT; g++) begin : g_cell
      ctw_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .cell_i (chain[g]),
         .cell_o (chain[g+1])
      );
   end

   assign last = chain[ctw_pkg::CELL_COUNT];

   // The chain yields floor(~T / (T + 1)); one more gives the work value.
   // Rejected targets report zero work.
   always_comb begin
      new_result.invalid = last.invalid;
      new_result.work    = last.invalid ? '0 :
                           last.nq + {{(ctw_pkg::WORK_W-1){1'b0}}, 1'b1};
   end

   assign take = enable & last.valid;
   assign pop  = out_valid_ff & rsp_tready;

   // Output register with a skid register behind it. When the skid holds a
   // result the chain is frozen, so nothing new arrives in that case.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (take) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = new_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = new_result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff.work;
   assign rsp_tuser  = out_data_ff.invalid;

   // A result can only sit in the skid register behind a held output.
   `CTW_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid full while output empty")

   // The skid fills only when the output was stalled in the cycle before.
   `CTW_ASSERT(a_skid_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready), "skid filled without a stall")

   // A rejected target reports zero work, an accepted one at least one.
   `CTW_ASSERT(a_work_matches_flag, clock, reset, rsp_tvalid |-> ((rsp_tdata == '0) == rsp_tuser), "work value disagrees with invalid flag")

   // Reset leaves both output entries empty.
   `CTW_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!rsp_tvalid && !skid_valid_ff), "output not empty after reset")

endmodule

`default_nettype wire
